// ----- rtl/ffr_pkg.sv -----
// shared types and constants for the feedback frame receiver
`timescale 1ns / 1ps

package ffr_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int SPAN_W   = 17;
  localparam int POS_W    = 32;
  localparam int CNT_W    = 5;
  localparam int CFG_W    = 17;

  // frame layout in words and bytes
  localparam int FRAME_BYTES   = 22;
  localparam int SUM_WORDS     = 10;
  localparam int SUM_IDX_W     = 4;

  localparam logic [CNT_W-1:0] LAST_BYTE_POS = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] CHK_LO_POS    = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] FIRST_DATA    = CNT_W'(2);

  // word positions inside the frame
  localparam int W_START = 0;
  localparam int W_CMD1  = 1;
  localparam int W_CMD2  = 2;
  localparam int W_SPDR  = 3;
  localparam int W_SPDL  = 4;
  localparam int W_CNTR  = 5;
  localparam int W_CNTL  = 6;
  localparam int W_BATT  = 7;
  localparam int W_TEMP  = 8;
  localparam int W_LED   = 9;

  // register reset values
  localparam logic [WORD_W-1:0]        START_WORD_RST = 16'hABCD;
  localparam logic signed [WORD_W-1:0] LOW_WRAP_RST   = 16'sd2700;
  localparam logic signed [WORD_W-1:0] HIGH_WRAP_RST  = 16'sd6300;
  localparam logic [SPAN_W-1:0]        COUNT_SPAN_RST = 17'd9000;

  // result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  typedef enum logic [1:0] {
    CFG_START_WORD,
    CFG_LOW_WRAP,
    CFG_HIGH_WRAP,
    CFG_COUNT_SPAN
  } cfg_idx_t;

endpackage

// ----- rtl/ffr_in_if.sv -----
// input byte channel
`timescale 1ns / 1ps

interface ffr_in_if import ffr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/ffr_out_if.sv -----
// result channel carrying one decoded frame
`timescale 1ns / 1ps

interface ffr_out_if import ffr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [WORD_W-1:0] command_one;
  logic signed [WORD_W-1:0] command_two;
  logic signed [WORD_W-1:0] speed_right;
  logic signed [WORD_W-1:0] speed_left;
  logic signed [POS_W-1:0]  position_right;
  logic signed [POS_W-1:0]  position_left;
  logic signed [WORD_W-1:0] battery_level;
  logic signed [WORD_W-1:0] board_heat;
  logic [WORD_W-1:0]        led_word;

  modport source (
    output valid, output status, output command_one, output command_two,
    output speed_right, output speed_left, output position_right,
    output position_left, output battery_level, output board_heat,
    output led_word, input ready
  );
  modport sink (
    input valid, input status, input command_one, input command_two,
    input speed_right, input speed_left, input position_right,
    input position_left, input battery_level, input board_heat,
    input led_word, output ready
  );
endinterface

// ----- rtl/ffr_cfg_if.sv -----
// configuration write channel
`timescale 1ns / 1ps

interface ffr_cfg_if import ffr_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_t         reg_index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// ----- rtl/feedback_frame_receiver.sv -----
// feedback frame receiver: sync word search, frame capture, checksum and wheel count extension
`timescale 1ns / 1ps

// Takes one serial byte per word on in_chan and hunts for the sync word (low byte
// first) at any alignment; a sync word always restarts capture, even inside a frame.
// After the sync word, 20 more bytes complete a 22-byte frame of eleven little-endian
// words. On the last byte the XOR of the first ten words is checked against the
// checksum word and the captured sync word against the current start_word. A good
// frame gives one word on out_chan with status 0, the echoed fields and both wheel
// counts extended across encoder wraparound; a bad frame gives status 1 with all
// other fields zero and leaves the wrap state alone. Bytes that complete no frame
// give nothing. Rate: one byte per clock, sustained. The result word is registered:
// the last byte of its frame passes an input register, then the result register, on
// its way to out_chan; the input side only stalls when a frame completes while
// the previous result is still held on out_chan. Configuration writes are always
// ready and take effect the next cycle.
module feedback_frame_receiver import ffr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ffr_in_if.sink    in_chan,
  ffr_out_if.source out_chan,
  ffr_cfg_if.sink   cfg_chan
);

  // configuration registers
  logic [WORD_W-1:0]        start_word_r;
  logic signed [WORD_W-1:0] low_wrap_r;
  logic signed [WORD_W-1:0] high_wrap_r;
  logic [SPAN_W-1:0]        count_span_r;

  // input register
  logic              in_v_r;
  logic [BYTE_W-1:0] in_byte_r;

  // parser state
  logic [BYTE_W-1:0] prev_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [WORD_W-1:0] word_r [SUM_WORDS];
  logic [BYTE_W-1:0] chk_lo_r;

  // wrap tracking
  logic [WORD_W-1:0]        wraps_right_r, wraps_right_nxt;
  logic [WORD_W-1:0]        wraps_left_r,  wraps_left_nxt;
  logic signed [WORD_W-1:0] last_right_r;
  logic signed [WORD_W-1:0] last_left_r;

  // output register
  logic                     out_v_r;
  logic                     status_r;
  logic signed [WORD_W-1:0] cmd1_r, cmd2_r, spdr_r, spdl_r, batt_r, temp_r;
  logic [WORD_W-1:0]        led_r;
  logic signed [POS_W-1:0]  posr_r, posl_r;

  logic              sync_hit;
  logic              done;
  logic              advance;
  logic              good;
  logic              write_byte;
  logic [WORD_W-1:0] xor_sum;
  logic [WORD_W-1:0] checksum;
  logic signed [WORD_W-1:0] cnt_right, cnt_left;
  logic [POS_W-1:0]         prod_right, prod_left;
  logic [POS_W-1:0]         pos_right, pos_left;

  // config writes are taken at any time
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_word_r <= START_WORD_RST;
      low_wrap_r   <= LOW_WRAP_RST;
      high_wrap_r  <= HIGH_WRAP_RST;
      count_span_r <= COUNT_SPAN_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        CFG_START_WORD: start_word_r <= cfg_chan.data[WORD_W-1:0];
        CFG_LOW_WRAP:   low_wrap_r   <= $signed(cfg_chan.data[WORD_W-1:0]);
        CFG_HIGH_WRAP:  high_wrap_r  <= $signed(cfg_chan.data[WORD_W-1:0]);
        CFG_COUNT_SPAN: count_span_r <= cfg_chan.data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // sync word is the previous byte low, the current byte high
  assign sync_hit = ({in_byte_r, prev_r} == start_word_r);
  // last byte of a frame, unless it restarts capture
  assign done     = in_v_r && !sync_hit && (count_r == LAST_BYTE_POS);
  // a completing byte needs the result register free
  assign advance  = in_v_r && (!done || !out_v_r || out_chan.ready);

  assign in_chan.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.rx_byte;
    end
  end

  // byte counter: 0 or 1 means hunting, 2..21 means inside a frame
  assign write_byte = !sync_hit && (count_r >= FIRST_DATA);

  always_comb begin
    count_nxt = count_r;
    if (sync_hit) begin
      count_nxt = FIRST_DATA;
    end else if (done) begin
      count_nxt = '0;
    end else if (write_byte) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      count_r <= '0;
    end else if (advance) begin
      prev_r  <= in_byte_r;
      count_r <= count_nxt;
    end
  end

  // frame store, words 0..9 plus the checksum low byte
  always_ff @(posedge clk) begin
    if (advance) begin
      if (sync_hit) begin
        word_r[W_START] <= {in_byte_r, prev_r};
      end else if (write_byte && count_r < CHK_LO_POS) begin
        if (count_r[0]) begin
          word_r[count_r[SUM_IDX_W:1]][WORD_W-1:BYTE_W] <= in_byte_r;
        end else begin
          word_r[count_r[SUM_IDX_W:1]][BYTE_W-1:0] <= in_byte_r;
        end
      end else if (write_byte && count_r == CHK_LO_POS) begin
        chk_lo_r <= in_byte_r;
      end
    end
  end

  // checksum test
  always_comb begin
    xor_sum = '0;
    for (int i = 0; i < SUM_WORDS; i++) begin
      xor_sum = xor_sum ^ word_r[i];
    end
  end

  assign checksum = {in_byte_r, chk_lo_r};
  assign good     = (word_r[W_START] == start_word_r) && (xor_sum == checksum);

  assign cnt_right = $signed(word_r[W_CNTR]);
  assign cnt_left  = $signed(word_r[W_CNTL]);

  // wrap multipliers: upward wrap wins over downward wrap
  always_comb begin
    wraps_right_nxt = wraps_right_r;
    if (cnt_right < low_wrap_r && last_right_r > high_wrap_r) begin
      wraps_right_nxt = wraps_right_r + WORD_W'(1);
    end else if (cnt_right > high_wrap_r && last_right_r < low_wrap_r) begin
      wraps_right_nxt = wraps_right_r - WORD_W'(1);
    end
    wraps_left_nxt = wraps_left_r;
    if (cnt_left < low_wrap_r && last_left_r > high_wrap_r) begin
      wraps_left_nxt = wraps_left_r + WORD_W'(1);
    end else if (cnt_left > high_wrap_r && last_left_r < low_wrap_r) begin
      wraps_left_nxt = wraps_left_r - WORD_W'(1);
    end
  end

  // signed multiplier times unsigned span, kept modulo 2^32
  assign prod_right = POS_W'($signed(wraps_right_nxt)) * POS_W'(count_span_r);
  assign prod_left  = POS_W'($signed(wraps_left_nxt)) * POS_W'(count_span_r);
  assign pos_right  = prod_right + POS_W'(cnt_right);
  assign pos_left   = prod_left + POS_W'(cnt_left);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wraps_right_r <= '0;
      wraps_left_r  <= '0;
      last_right_r  <= '0;
      last_left_r   <= '0;
    end else if (advance && done && good) begin
      wraps_right_r <= wraps_right_nxt;
      wraps_left_r  <= wraps_left_nxt;
      last_right_r  <= cnt_right;
      last_left_r   <= cnt_left;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && done) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      if (good) begin
        status_r <= STATUS_OK;
        cmd1_r   <= $signed(word_r[W_CMD1]);
        cmd2_r   <= $signed(word_r[W_CMD2]);
        spdr_r   <= $signed(word_r[W_SPDR]);
        spdl_r   <= $signed(word_r[W_SPDL]);
        posr_r   <= $signed(pos_right);
        posl_r   <= $signed(pos_left);
        batt_r   <= $signed(word_r[W_BATT]);
        temp_r   <= $signed(word_r[W_TEMP]);
        led_r    <= word_r[W_LED];
      end else begin
        // mismatch: status set, all other fields cleared
        status_r <= STATUS_MISMATCH;
        cmd1_r   <= '0;
        cmd2_r   <= '0;
        spdr_r   <= '0;
        spdl_r   <= '0;
        posr_r   <= '0;
        posl_r   <= '0;
        batt_r   <= '0;
        temp_r   <= '0;
        led_r    <= '0;
      end
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.status         = status_r;
  assign out_chan.command_one    = cmd1_r;
  assign out_chan.command_two    = cmd2_r;
  assign out_chan.speed_right    = spdr_r;
  assign out_chan.speed_left     = spdl_r;
  assign out_chan.position_right = posr_r;
  assign out_chan.position_left  = posl_r;
  assign out_chan.battery_level  = batt_r;
  assign out_chan.board_heat     = temp_r;
  assign out_chan.led_word       = led_r;

endmodule

// ----- tb/sv/feedback_frame_receiver_test.sv -----
// testbench for the feedback frame receiver: byte stream driver, frame predictor, result checker
`timescale 1ns / 1ps

module feedback_frame_receiver_test;
  import ffr_pkg::*;

  // checksum word sits right after the ten summed words
  localparam int W_SUM = SUM_WORDS;
  localparam int FRAME_WORDS = SUM_WORDS + 1;
  // cycles with no word moving on any channel before the run is called dead
  localparam int STALL_LIMIT = 1500;
  // phases of random traffic and the frame bytes spent in each
  localparam int PHASES = 5;
  localparam int PHASE_BYTES = 310;

  typedef struct {
    logic                     status;
    logic signed [WORD_W-1:0] command_one;
    logic signed [WORD_W-1:0] command_two;
    logic signed [WORD_W-1:0] speed_right;
    logic signed [WORD_W-1:0] speed_left;
    logic signed [POS_W-1:0]  position_right;
    logic signed [POS_W-1:0]  position_left;
    logic signed [WORD_W-1:0] battery_level;
    logic signed [WORD_W-1:0] board_heat;
    logic [WORD_W-1:0]        led_word;
  } frame_result_t;

  // mirrors the receiver: sync hunt, capture, checksum and count extension
  class frame_tracker;
    logic [WORD_W-1:0]        start_word;
    logic signed [WORD_W-1:0] low_wrap;
    logic signed [WORD_W-1:0] high_wrap;
    logic [SPAN_W-1:0]        count_span;
    logic [BYTE_W-1:0]        prev_byte;
    int unsigned              bytes_taken;
    logic [WORD_W-1:0]        words [FRAME_WORDS];
    logic [WORD_W-1:0]        wraps_right, wraps_left;
    logic signed [WORD_W-1:0] last_right, last_left;
    frame_result_t            expected_frames [$];
    int                       errors;
    string field_names [10] = '{"status", "command_one", "command_two", "speed_right",
                                "speed_left", "position_right", "position_left",
                                "battery_level", "board_heat", "led_word"};

    function void clear();
      start_word  = START_WORD_RST;
      low_wrap    = LOW_WRAP_RST;
      high_wrap   = HIGH_WRAP_RST;
      count_span  = COUNT_SPAN_RST;
      prev_byte   = '0;
      bytes_taken = 0;
      foreach (words[i]) words[i] = '0;
      wraps_right = '0;
      wraps_left  = '0;
      last_right  = '0;
      last_left   = '0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_START_WORD: start_word = data[WORD_W-1:0];
        CFG_LOW_WRAP:   low_wrap   = data[WORD_W-1:0];
        CFG_HIGH_WRAP:  high_wrap  = data[WORD_W-1:0];
        CFG_COUNT_SPAN: count_span = data[SPAN_W-1:0];
        default: ;
      endcase
    endfunction

    function void place(logic [BYTE_W-1:0] b);
      if (bytes_taken / 2 >= FRAME_WORDS) return;
      if (bytes_taken % 2) words[bytes_taken / 2][15:8] = b;
      else words[bytes_taken / 2][7:0] = b;
      bytes_taken++;
    endfunction

    function logic [POS_W-1:0] extend_count(logic signed [WORD_W-1:0] now,
                                            inout logic signed [WORD_W-1:0] last,
                                            inout logic [WORD_W-1:0] wraps);
      logic [POS_W-1:0] scaled;
      // upward wrap wins over downward
      if (now < low_wrap && last > high_wrap) wraps = wraps + 1'b1;
      else if (now > high_wrap && last < low_wrap) wraps = wraps - 1'b1;
      last = now;
      scaled = POS_W'($signed(wraps)) * POS_W'(count_span);
      return POS_W'(now) + scaled;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] sync, sum;
      frame_result_t r;
      sync = {b, prev_byte};
      if (sync == start_word) begin
        bytes_taken = 0;
        place(prev_byte);
        place(b);
      end else if (bytes_taken >= 2 && bytes_taken < FRAME_BYTES) begin
        place(b);
      end
      if (bytes_taken == FRAME_BYTES) begin
        sum = '0;
        for (int i = 0; i < SUM_WORDS; i++) sum ^= words[i];
        r = '{default: '0};
        if (words[W_START] == start_word && words[W_SUM] == sum) begin
          r.status         = STATUS_OK;
          r.command_one    = words[W_CMD1];
          r.command_two    = words[W_CMD2];
          r.speed_right    = words[W_SPDR];
          r.speed_left     = words[W_SPDL];
          r.position_right = extend_count(words[W_CNTR], last_right, wraps_right);
          r.position_left  = extend_count(words[W_CNTL], last_left, wraps_left);
          r.battery_level  = words[W_BATT];
          r.board_heat     = words[W_TEMP];
          r.led_word       = words[W_LED];
        end else begin
          r.status = STATUS_MISMATCH;
        end
        expected_frames.push_back(r);
        bytes_taken = 0;
      end
      prev_byte = b;
    endfunction

    function void flatten(frame_result_t r, output logic [31:0] f [10]);
      f[0] = r.status;
      f[1] = r.command_one;
      f[2] = r.command_two;
      f[3] = r.speed_right;
      f[4] = r.speed_left;
      f[5] = r.position_right;
      f[6] = r.position_left;
      f[7] = r.battery_level;
      f[8] = r.board_heat;
      f[9] = r.led_word;
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(frame_result_t got);
      frame_result_t want;
      logic [31:0] g [10];
      logic [31:0] w [10];
      if (expected_frames.size() == 0) begin
        report("result word with no frame pending");
        return;
      end
      want = expected_frames.pop_front();
      flatten(got, g);
      flatten(want, w);
      for (int i = 0; i < 10; i++)
        if (g[i] !== w[i])
          report($sformatf("%s got %h expected %h", field_names[i], g[i], w[i]));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ffr_in_if  in_chan ();
  ffr_out_if out_chan ();
  ffr_cfg_if cfg_chan ();

  feedback_frame_receiver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  frame_tracker  tracker;
  frame_result_t seen;
  logic [WORD_W-1:0] frame_words [FRAME_WORDS];
  bit steady;        // no gaps and no new stalls while set
  int stall_left;
  int quiet_cycles;

  always #10 clk = ~clk;

  // receiver side: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      out_chan.ready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      out_chan.ready <= 1'b0;
    end
  end

  // every accepted result word goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.status         = out_chan.status;
      seen.command_one    = out_chan.command_one;
      seen.command_two    = out_chan.command_two;
      seen.speed_right    = out_chan.speed_right;
      seen.speed_left     = out_chan.speed_left;
      seen.position_right = out_chan.position_right;
      seen.position_left  = out_chan.position_left;
      seen.battery_level  = out_chan.battery_level;
      seen.board_heat     = out_chan.board_heat;
      seen.led_word       = out_chan.led_word;
      tracker.check_result(seen);
    end
  end

  // watchdog: too long with nothing moving on any channel
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // gap before a byte: usually none, some short, a few long
  function int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // a wheel count near the wrap thresholds, at an extreme, or random
  function logic [WORD_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return tracker.low_wrap - WORD_W'($urandom_range(1, 300));
      1: return tracker.high_wrap + WORD_W'($urandom_range(1, 300));
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  function logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // one byte word on the input channel, held until taken
  task send_byte(logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    tracker.take_byte(b);
  endtask

  // leaves cfg valid high; the caller drops it after the last write
  task write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.data      <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    tracker.write_reg(idx, data);
  endtask

  // sender holds off until every pending frame is out and the pipe is empty
  task settle();
    in_chan.valid <= 1'b0;
    while (tracker.expected_frames.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task apply_settings(logic [WORD_W-1:0] sw, logic [WORD_W-1:0] lo,
                      logic [WORD_W-1:0] hi, logic [SPAN_W-1:0] span);
    settle();
    write_reg(CFG_START_WORD, {1'b0, sw});
    write_reg(CFG_LOW_WRAP, {1'b0, lo});
    write_reg(CFG_HIGH_WRAP, {1'b0, hi});
    write_reg(CFG_COUNT_SPAN, span);
    cfg_chan.valid <= 1'b0;
  endtask

  task fill_frame();
    for (int i = 1; i < SUM_WORDS; i++)
      frame_words[i] = (i == W_CNTR || i == W_CNTL) ? pick_count() : pick_word();
  endtask

  // sync word up front, checksum at the back, optionally broken
  task seal_frame(bit corrupt);
    logic [WORD_W-1:0] sum;
    frame_words[W_START] = tracker.start_word;
    sum = '0;
    for (int i = 0; i < SUM_WORDS; i++) sum ^= frame_words[i];
    frame_words[W_SUM] = corrupt ? sum ^ WORD_W'($urandom_range(1, 65535)) : sum;
  endtask

  // frame bytes go out low byte first
  task send_frame(int first, int count);
    for (int k = first; k < first + count; k++)
      send_byte((k % 2) ? frame_words[k / 2][15:8] : frame_words[k / 2][7:0]);
  endtask

  initial begin
    int frame_bytes, pick, cut;
    tracker = new();
    tracker.clear();
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.rx_byte    = '0;
    out_chan.ready     = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.reg_index = CFG_START_WORD;
    cfg_chan.data      = '0;
    steady             = 1'b0;
    stall_left         = 0;
    quiet_cycles       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // stray bytes before any sync word
    send_byte(8'h00);
    send_byte(8'hcd);
    send_byte(8'h12);

    // good frame with extreme fields, right count wraps downward from zero
    frame_words = '{16'h0000, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h7fff,
                    16'h8000, 16'h5555, 16'haaaa, 16'hffff, 16'h0000};
    seal_frame(1'b0);
    send_frame(0, FRAME_BYTES);

    // counts swing back: right wraps up, left wraps down
    frame_words[W_CNTR] = 16'h0000;
    frame_words[W_CNTL] = 16'h7fff;
    seal_frame(1'b0);
    send_frame(0, FRAME_BYTES);

    // broken checksum
    seal_frame(1'b1);
    send_frame(0, FRAME_BYTES);

    // sync word inside a frame drops the partial frame
    fill_frame();
    seal_frame(1'b0);
    send_frame(0, 9);
    fill_frame();
    seal_frame(1'b0);
    send_frame(0, FRAME_BYTES);

    // start word moved while a frame is half captured gives a mismatch
    fill_frame();
    seal_frame(1'b0);
    send_frame(0, 10);
    settle();
    write_reg(CFG_START_WORD, 17'h01357);
    cfg_chan.valid <= 1'b0;
    send_frame(10, FRAME_BYTES - 10);
    settle();
    write_reg(CFG_START_WORD, {1'b0, START_WORD_RST});
    cfg_chan.valid <= 1'b0;

    // random traffic under several register settings, extremes included
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: apply_settings(16'hffff, 16'h8000, 16'h7fff, 17'h10000);
        2: apply_settings(16'h0000, 16'h7fff, 16'h8000, 17'h00001);
        3: apply_settings(WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
                          SPAN_W'($urandom_range(1, 65536)));
        4: apply_settings(START_WORD_RST, LOW_WRAP_RST, HIGH_WRAP_RST, COUNT_SPAN_RST);
        default: ;
      endcase
      frame_bytes = 0;
      while (frame_bytes < PHASE_BYTES) begin
        steady = ($urandom_range(0, 5) == 0);
        // line noise between frames
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
        fill_frame();
        pick = $urandom_range(0, 99);
        seal_frame(pick >= 78 && pick < 90);
        // some frames are cut short and overrun by the next sync word
        cut = (pick >= 90) ? $urandom_range(2, FRAME_BYTES - 1) : FRAME_BYTES;
        send_frame(0, cut);
        frame_bytes += cut;
        if ($urandom_range(0, 24) == 0) settle();
      end
    end

    // drain, then give the pipe time to show any extra result words
    steady = 1'b0;
    in_chan.valid <= 1'b0;
    while (tracker.expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.expected_frames.size() != 0) tracker.report("frames never reported");
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
